FILE: rtl/pdca_pkg.sv
// Package for the PWM duty capture averager.
// Holds sequencer states, status codes, capture steps and divider constants.
// No dependencies.
package pdca_pkg;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_FIN
    } t_state;

    typedef enum logic [1:0] {
        CAP_RISE1,
        CAP_FALL,
        CAP_RISE2,
        CAP_SPARE
    } t_cap_step;

    localparam logic [2:0] ST_NONE       = 3'd0;
    localparam logic [2:0] ST_AVERAGED   = 3'd1;
    localparam logic [2:0] ST_STUCK_LOW  = 3'd2;
    localparam logic [2:0] ST_STUCK_HIGH = 3'd3;
    localparam logic [2:0] ST_ORDER_ERR  = 3'd4;

    localparam logic [6:0] DUTY_FULL  = 7'd100;
    localparam logic [6:0] DUTY_ZERO  = 7'd0;
    localparam int         DUTY_SCALE = 100;

    // quotient bits produced by the shared divider in each mode
    localparam int DUTY_STEPS = 7;
    localparam int AVG_STEPS  = 11;

    localparam logic [15:0] RST_CHECK_INTERVAL = 16'd3000;
    localparam logic [3:0]  RST_SAMPLE_COUNT   = 4'd10;

    localparam logic ADDR_CHECK_INTERVAL = 1'b0;
    localparam logic ADDR_SAMPLE_COUNT   = 1'b1;

endpackage

FILE: rtl/pwm_duty_capture_averager_unit.sv
// PWM duty capture averager, top level.
// Capture sequencing, tick checks, APB registers and one shared restoring divider.
// Depends on pdca_pkg.

// Usage:
// Input channel (i_in_valid / o_in_stall) carries one item per event: a system
// tick (kind 1, with pin level) or a timestamped captured edge (kind 0).
// Every item yields exactly one result on the output channel
// (o_out_valid / i_out_stall): the published duty, its status and an updated flag.
// Ticks, ignored edges, the first two capture edges and order errors finish in
// the accept cycle; the result is valid the next cycle, one item per cycle while
// the receiver keeps up.
// A third capture edge runs the shared divider one quotient bit per cycle:
// 7 quotient bits for a duty sample or 11 for an average, then a finish
// state; no next item is accepted before the finish state has published the result.
// While a result waits under i_out_stall, o_in_stall stays high, so no new
// item is taken and the result register never drops an item.
// Synchronous reset restores the default registers (interval 3000 ticks,
// 10 samples), disarms capture and publishes "no reading" with duty 0.
// The APB port (pready always high) must be written only while the block is idle; the block does not enforce this.
module pwm_duty_capture_averager_unit #(
    parameter int TIMER_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_kind,
    input  logic [15:0] i_edge_time,
    input  logic        i_edge_rising,
    input  logic        i_pin_level,

    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [6:0]  o_duty_percent,
    output logic [2:0]  o_status,
    output logic        o_updated,

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // stamps are the timer value masked to the timer width
    localparam int SW = (TIMER_BITS < 16) ? TIMER_BITS : 16;
    // dividend width: stamp difference times 100
    localparam int NW = SW + 7;

    pdca_pkg::t_state    r_state, n_state;
    pdca_pkg::t_cap_step r_step, n_step;

    logic [15:0]   r_check_interval;
    logic [3:0]    r_sample_count;

    logic          r_armed, n_armed;
    logic          r_edge_seen, n_edge_seen;
    logic [SW-1:0] r_rise_time, n_rise_time;
    logic [SW-1:0] r_fall_time, n_fall_time;
    logic [15:0]   r_tick_count, n_tick_count;
    logic [3:0]    r_samples, n_samples;
    logic [10:0]   r_duty_sum, n_duty_sum;
    logic [6:0]    r_pub_duty, n_pub_duty;
    logic [2:0]    r_pub_status, n_pub_status;

    logic          r_out_valid, n_out_valid;
    logic          r_updated, n_updated;

    // shared divider
    logic [NW-1:0] r_rem, n_rem;
    logic [NW-1:0] r_dsh, n_dsh;
    logic [10:0]   r_quo, n_quo;
    logic [3:0]    r_cnt, n_cnt;
    logic          r_avg, n_avg;

    logic          accept;
    logic          out_free;
    logic          cfg_wr;
    logic [SW-1:0] stamp;
    logic [15:0]   tick_inc;
    logic          order_ok;
    logic [SW-1:0] diff_ba;
    logic [SW-1:0] diff_ca;
    logic [3:0]    avg_div;
    logic          div_fits;
    logic          last_capture;

    assign out_free = !r_out_valid || !i_out_stall;
    assign accept   = i_in_valid && !o_in_stall;
    assign cfg_wr   = psel && penable && pwrite;
    assign stamp    = i_edge_time[SW-1:0];
    assign tick_inc = r_tick_count + 16'd1;
    assign order_ok = (r_rise_time < r_fall_time) && (r_fall_time < stamp);
    assign diff_ba  = r_fall_time - r_rise_time;
    assign diff_ca  = stamp - r_rise_time;
    assign avg_div  = (r_sample_count == 4'd0) ? 4'd1 : r_sample_count;
    assign div_fits = (r_rem >= r_dsh);
    assign last_capture = accept && !i_kind && r_armed && i_edge_rising
                          && (r_step != pdca_pkg::CAP_RISE1)
                          && (r_step != pdca_pkg::CAP_FALL);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            pdca_pkg::S_IDLE: begin
                if (last_capture && order_ok) begin
                    n_state = pdca_pkg::S_DIV;
                end
            end
            pdca_pkg::S_DIV: begin
                if (r_cnt == 4'd0) begin
                    n_state = pdca_pkg::S_FIN;
                end
            end
            pdca_pkg::S_FIN: begin
                if (out_free) begin
                    n_state = pdca_pkg::S_IDLE;
                end
            end
            default: n_state = pdca_pkg::S_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        o_in_stall = (r_state != pdca_pkg::S_IDLE) || !out_free;
    end

    // datapath
    always_comb begin
        n_step       = r_step;
        n_armed      = r_armed;
        n_edge_seen  = r_edge_seen;
        n_rise_time  = r_rise_time;
        n_fall_time  = r_fall_time;
        n_tick_count = r_tick_count;
        n_samples    = r_samples;
        n_duty_sum   = r_duty_sum;
        n_pub_duty   = r_pub_duty;
        n_pub_status = r_pub_status;
        n_out_valid  = r_out_valid && i_out_stall;
        n_updated    = r_updated;
        n_rem        = r_rem;
        n_dsh        = r_dsh;
        n_quo        = r_quo;
        n_cnt        = r_cnt;
        n_avg        = r_avg;

        unique case (r_state)
            pdca_pkg::S_IDLE: begin
                if (accept) begin
                    n_out_valid = 1'b1;
                    n_updated   = 1'b0;
                    if (i_kind) begin
                        n_tick_count = tick_inc;
                        if (tick_inc >= r_check_interval) begin
                            n_tick_count = 16'd0;
                            if (r_edge_seen) begin
                                n_armed     = 1'b1;
                                n_step      = pdca_pkg::CAP_RISE1;
                                n_edge_seen = 1'b0;
                            end else begin
                                n_pub_duty   = i_pin_level ? pdca_pkg::DUTY_FULL
                                                           : pdca_pkg::DUTY_ZERO;
                                n_pub_status = i_pin_level ? pdca_pkg::ST_STUCK_HIGH
                                                           : pdca_pkg::ST_STUCK_LOW;
                                n_updated    = 1'b1;
                            end
                        end
                    end else if (r_armed) begin
                        unique case (r_step)
                            pdca_pkg::CAP_RISE1: begin
                                if (i_edge_rising) begin
                                    n_edge_seen = 1'b1;
                                    n_rise_time = stamp;
                                    n_step      = pdca_pkg::CAP_FALL;
                                end
                            end
                            pdca_pkg::CAP_FALL: begin
                                if (!i_edge_rising) begin
                                    n_edge_seen = 1'b1;
                                    n_fall_time = stamp;
                                    n_step      = pdca_pkg::CAP_RISE2;
                                end
                            end
                            default: begin
                                if (i_edge_rising) begin
                                    n_edge_seen = 1'b1;
                                    n_armed     = 1'b0;
                                    n_step      = pdca_pkg::CAP_RISE1;
                                    if (!order_ok) begin
                                        n_pub_duty   = pdca_pkg::DUTY_ZERO;
                                        n_pub_status = pdca_pkg::ST_ORDER_ERR;
                                        n_updated    = 1'b1;
                                    end else begin
                                        // result comes from the divider
                                        n_out_valid = 1'b0;
                                        n_quo       = 11'd0;
                                        if (r_samples < r_sample_count) begin
                                            n_avg = 1'b0;
                                            n_rem = NW'(diff_ba) * NW'(pdca_pkg::DUTY_SCALE);
                                            n_dsh = NW'(diff_ca) << (pdca_pkg::DUTY_STEPS - 1);
                                            n_cnt = 4'(pdca_pkg::DUTY_STEPS - 1);
                                        end else begin
                                            n_avg = 1'b1;
                                            n_rem = NW'(r_duty_sum);
                                            n_dsh = NW'(avg_div) << (pdca_pkg::AVG_STEPS - 1);
                                            n_cnt = 4'(pdca_pkg::AVG_STEPS - 1);
                                        end
                                    end
                                end
                            end
                        endcase
                    end
                end
            end
            pdca_pkg::S_DIV: begin
                // one quotient bit per cycle against the shifted divisor
                if (div_fits) begin
                    n_rem = r_rem - r_dsh;
                end
                n_quo = {r_quo[9:0], div_fits};
                n_dsh = r_dsh >> 1;
                n_cnt = r_cnt - 4'd1;
            end
            pdca_pkg::S_FIN: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    if (r_avg) begin
                        n_pub_duty   = r_quo[6:0];
                        n_pub_status = pdca_pkg::ST_AVERAGED;
                        n_samples    = 4'd0;
                        n_duty_sum   = 11'd0;
                        n_updated    = 1'b1;
                    end else begin
                        n_samples  = r_samples + 4'd1;
                        n_duty_sum = r_duty_sum + {4'd0, r_quo[6:0]};
                        n_updated  = 1'b0;
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state          <= pdca_pkg::S_IDLE;
            r_step           <= pdca_pkg::CAP_RISE1;
            r_check_interval <= pdca_pkg::RST_CHECK_INTERVAL;
            r_sample_count   <= pdca_pkg::RST_SAMPLE_COUNT;
            r_armed          <= 1'b0;
            r_edge_seen      <= 1'b1;
            r_tick_count     <= 16'd0;
            r_samples        <= 4'd0;
            r_duty_sum       <= 11'd0;
            r_pub_duty       <= pdca_pkg::DUTY_ZERO;
            r_pub_status     <= pdca_pkg::ST_NONE;
            r_out_valid      <= 1'b0;
            r_updated        <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_step       <= n_step;
            r_armed      <= n_armed;
            r_edge_seen  <= n_edge_seen;
            r_tick_count <= n_tick_count;
            r_samples    <= n_samples;
            r_duty_sum   <= n_duty_sum;
            r_pub_duty   <= n_pub_duty;
            r_pub_status <= n_pub_status;
            r_out_valid  <= n_out_valid;
            r_updated    <= n_updated;
            if (cfg_wr) begin
                unique case (paddr[2])
                    pdca_pkg::ADDR_CHECK_INTERVAL: r_check_interval <= pwdata[15:0];
                    pdca_pkg::ADDR_SAMPLE_COUNT:   r_sample_count   <= pwdata[3:0];
                    default: ;
                endcase
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge i_clk) begin
        r_rise_time <= n_rise_time;
        r_fall_time <= n_fall_time;
        r_rem       <= n_rem;
        r_dsh       <= n_dsh;
        r_quo       <= n_quo;
        r_cnt       <= n_cnt;
        r_avg       <= n_avg;
    end

    always_comb begin
        unique case (paddr[2])
            pdca_pkg::ADDR_CHECK_INTERVAL: prdata = {16'd0, r_check_interval};
            pdca_pkg::ADDR_SAMPLE_COUNT:   prdata = {28'd0, r_sample_count};
            default:                       prdata = 32'd0;
        endcase
    end

    assign pready         = 1'b1;
    assign o_out_valid    = r_out_valid;
    assign o_duty_percent = r_pub_duty;
    assign o_status       = r_pub_status;
    assign o_updated      = r_updated;

endmodule
